FILE: rtl/lwws_pkg.sv
// shared types, constants and the rotation table for the lcd window write sequencer
// no dependencies
package lwws_pkg;

  localparam int COORD_BITS  = 10;
  localparam int LEFT_BITS   = 2 * COORD_BITS + 1;
  localparam int ADDR_BITS   = 16;
  localparam int COLOR_BITS  = 16;
  localparam int OP_BITS     = 4;
  localparam int DIR_BITS    = 2;
  localparam int BYTE_BITS   = 8;
  localparam int CFG_IDX_BITS = 4;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  // opcodes
  localparam logic [OP_BITS-1:0] OP_PIXEL   = 4'd0;
  localparam logic [OP_BITS-1:0] OP_RUN     = 4'd1;
  localparam logic [OP_BITS-1:0] OP_WINDOW  = 4'd2;
  localparam logic [OP_BITS-1:0] OP_COLOR   = 4'd3;
  localparam logic [OP_BITS-1:0] OP_ROTATE  = 4'd4;
  localparam logic [OP_BITS-1:0] OP_DISP_OFF = 4'd5;
  localparam logic [OP_BITS-1:0] OP_DISP_ON  = 4'd6;
  localparam logic [OP_BITS-1:0] OP_INV_OFF  = 4'd7;
  localparam logic [OP_BITS-1:0] OP_INV_ON   = 4'd8;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_PANEL_WIDTH  = 4'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PANEL_HEIGHT = 4'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_COL_OFFSET   = 4'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ROW_OFFSET   = 4'd3;

  localparam logic [COORD_BITS-1:0] RST_PANEL_WIDTH  = COORD_BITS'(240);
  localparam logic [COORD_BITS-1:0] RST_PANEL_HEIGHT = COORD_BITS'(320);

  // panel commands
  localparam logic [BYTE_BITS-1:0] CMD_CASET    = 8'h2A;
  localparam logic [BYTE_BITS-1:0] CMD_RASET    = 8'h2B;
  localparam logic [BYTE_BITS-1:0] CMD_RAMWR    = 8'h2C;
  localparam logic [BYTE_BITS-1:0] CMD_MADCTL   = 8'h36;
  localparam logic [BYTE_BITS-1:0] CMD_DISP_OFF = 8'h28;
  localparam logic [BYTE_BITS-1:0] CMD_DISP_ON  = 8'h29;
  localparam logic [BYTE_BITS-1:0] CMD_INV_OFF  = 8'h20;
  localparam logic [BYTE_BITS-1:0] CMD_INV_ON   = 8'h21;
  localparam logic [BYTE_BITS-1:0] MAD_MY       = 8'h80;
  localparam logic [BYTE_BITS-1:0] MAD_MX       = 8'h40;
  localparam logic [BYTE_BITS-1:0] MAD_MV       = 8'h20;
  localparam logic [BYTE_BITS-1:0] BYTE_MASK    = 8'hFF;

  // job kinds
  localparam logic [1:0] JOB_WIN   = 2'd0;
  localparam logic [1:0] JOB_COLOR = 2'd1;
  localparam logic [1:0] JOB_CMD   = 2'd2;

  typedef struct packed {
    logic [OP_BITS-1:0]    opcode;
    logic [COORD_BITS-1:0] x_start;
    logic [COORD_BITS-1:0] y_start;
    logic [COORD_BITS-1:0] x_end;
    logic [COORD_BITS-1:0] y_end;
    logic [COORD_BITS-1:0] run_length;
    logic [COLOR_BITS-1:0] color;
    logic [DIR_BITS-1:0]   direction;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_BITS-1:0] out_byte;
    logic                 is_data;
    logic                 last_byte;
  } out_item_t;

  typedef struct packed {
    logic [1:0]            kind;
    logic                  with_color;
    logic                  has_data;
    logic [ADDR_BITS-1:0]  x1;
    logic [ADDR_BITS-1:0]  x2;
    logic [ADDR_BITS-1:0]  y1;
    logic [ADDR_BITS-1:0]  y2;
    logic [COLOR_BITS-1:0] color;
    logic [BYTE_BITS-1:0]  cmd;
    logic [BYTE_BITS-1:0]  data;
  } job_t;

  function automatic logic [BYTE_BITS-1:0] rot_code(input logic [DIR_BITS-1:0] dir);
    logic [BYTE_BITS-1:0] code;
    case (dir)
      2'd0: code = '0;
      2'd1: code = MAD_MX | MAD_MV;
      2'd2: code = MAD_MX | MAD_MY;
      default: code = MAD_MY | MAD_MV;
    endcase
    return code;
  endfunction

endpackage

FILE: rtl/lwws_front.sv
// front end: configuration registers, request classification and the open pixel count
// depends on lwws_pkg; feeds lwws_queue
module lwws_front (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [lwws_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [lwws_pkg::COORD_BITS-1:0]       cfg_data,
  input  logic                                  push,
  input  lwws_pkg::in_item_t                    in_data,
  input  logic                                  q_full,
  output logic                                  q_push,
  output lwws_pkg::job_t                        q_job
);
  import lwws_pkg::*;

  logic [COORD_BITS-1:0] width_r, height_r, col_off_r, row_off_r;
  logic [LEFT_BITS-1:0]  left_r, left_nxt;

  logic                  accept;
  logic [COORD_BITS:0]   x_off, y_off, run_sum, dx, dy;
  logic [COORD_BITS+1:0] run_end;
  logic [LEFT_BITS-1:0]  area;
  logic                  pix_ok, run_ok, win_ok;

  assign cfg_ready = 1'b1;
  assign accept    = push && !q_full;

  always_comb begin
    x_off   = {1'b0, in_data.x_start} + {1'b0, col_off_r};
    y_off   = {1'b0, in_data.y_start} + {1'b0, row_off_r};
    run_sum = {1'b0, in_data.x_start} + {1'b0, in_data.run_length};
    run_end = {1'b0, x_off} + {2'b0, in_data.run_length} - (COORD_BITS+2)'(1);
    dx      = {1'b0, in_data.x_end} - {1'b0, in_data.x_start} + (COORD_BITS+1)'(1);
    dy      = {1'b0, in_data.y_end} - {1'b0, in_data.y_start} + (COORD_BITS+1)'(1);
    area    = LEFT_BITS'(dx) * LEFT_BITS'(dy);
    pix_ok  = (in_data.x_start < width_r) && (in_data.y_start < height_r);
    run_ok  = (in_data.run_length != '0) && (run_sum <= {1'b0, width_r}) &&
              (in_data.y_start < height_r);
    win_ok  = (in_data.x_end >= in_data.x_start) && (in_data.y_end >= in_data.y_start);
  end

  always_comb begin
    q_push          = 1'b0;
    left_nxt        = left_r;
    q_job           = '0;
    q_job.color     = in_data.color;
    if (accept) begin
      case (in_data.opcode)
        OP_PIXEL: begin
          if (pix_ok) begin
            left_nxt         = '0;
            q_push           = 1'b1;
            q_job.kind       = JOB_WIN;
            q_job.with_color = 1'b1;
            q_job.x1         = ADDR_BITS'(x_off);
            q_job.x2         = ADDR_BITS'(x_off);
            q_job.y1         = ADDR_BITS'(y_off);
            q_job.y2         = ADDR_BITS'(y_off);
          end
        end
        OP_RUN: begin
          left_nxt = '0;
          if (run_ok) begin
            left_nxt   = LEFT_BITS'(in_data.run_length);
            q_push     = 1'b1;
            q_job.kind = JOB_WIN;
            q_job.x1   = ADDR_BITS'(x_off);
            q_job.x2   = ADDR_BITS'(run_end);
            q_job.y1   = ADDR_BITS'(y_off);
            q_job.y2   = ADDR_BITS'(y_off);
          end
        end
        OP_WINDOW: begin
          left_nxt = '0;
          if (win_ok) begin
            left_nxt   = area;
            q_push     = 1'b1;
            q_job.kind = JOB_WIN;
            q_job.x1   = ADDR_BITS'(in_data.x_start);
            q_job.x2   = ADDR_BITS'(in_data.x_end);
            q_job.y1   = ADDR_BITS'(in_data.y_start);
            q_job.y2   = ADDR_BITS'(in_data.y_end);
          end
        end
        OP_COLOR: begin
          if (left_r != '0) begin
            left_nxt   = left_r - LEFT_BITS'(1);
            q_push     = 1'b1;
            q_job.kind = JOB_COLOR;
          end
        end
        OP_ROTATE: begin
          left_nxt       = '0;
          q_push         = 1'b1;
          q_job.kind     = JOB_CMD;
          q_job.cmd      = CMD_MADCTL;
          q_job.has_data = 1'b1;
          q_job.data     = rot_code(in_data.direction);
        end
        OP_DISP_OFF: begin
          left_nxt   = '0;
          q_push     = 1'b1;
          q_job.kind = JOB_CMD;
          q_job.cmd  = CMD_DISP_OFF;
        end
        OP_DISP_ON: begin
          left_nxt   = '0;
          q_push     = 1'b1;
          q_job.kind = JOB_CMD;
          q_job.cmd  = CMD_DISP_ON;
        end
        OP_INV_OFF: begin
          left_nxt   = '0;
          q_push     = 1'b1;
          q_job.kind = JOB_CMD;
          q_job.cmd  = CMD_INV_OFF;
        end
        OP_INV_ON: begin
          left_nxt   = '0;
          q_push     = 1'b1;
          q_job.kind = JOB_CMD;
          q_job.cmd  = CMD_INV_ON;
        end
        default: begin
          left_nxt = left_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= RST_PANEL_WIDTH;
      height_r  <= RST_PANEL_HEIGHT;
      col_off_r <= '0;
      row_off_r <= '0;
      left_r    <= '0;
    end else begin
      left_r <= left_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PANEL_WIDTH:  width_r   <= cfg_data;
          CFG_PANEL_HEIGHT: height_r  <= cfg_data;
          CFG_COL_OFFSET:   col_off_r <= cfg_data;
          CFG_ROW_OFFSET:   row_off_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule

FILE: rtl/lwws_queue.sv
// short job queue between the front end and the byte sequencer
// depends on lwws_pkg
module lwws_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_i,
  input  lwws_pkg::job_t job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output lwws_pkg::job_t job_o
);
  import lwws_pkg::*;

  job_t                 mem_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_BITS-1:0] cnt_r, cnt_nxt;

  assign full_o  = (cnt_r == QCNT_BITS'(QUEUE_DEPTH));
  assign valid_o = (cnt_r != '0);
  assign job_o   = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push_i && !pop_i) begin
      cnt_nxt = cnt_r + QCNT_BITS'(1);
    end else if (pop_i && !push_i) begin
      cnt_nxt = cnt_r - QCNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_ptr_r] <= job_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push_i) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_BITS'(1);
      end
      if (pop_i) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_BITS'(1);
      end
    end
  end

endmodule

FILE: rtl/lwws_back.sv
// back end: steps through one job at a time and fills the output register
// depends on lwws_pkg; reads jobs from lwws_queue
module lwws_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  lwws_pkg::job_t        q_job,
  output logic                  q_pop,
  output logic                  empty,
  input  logic                  pop,
  output lwws_pkg::out_item_t   out_data
);
  import lwws_pkg::*;

  localparam int STEP_BITS = 4;
  localparam logic [STEP_BITS-1:0] STEP_CASET    = 4'd0;
  localparam logic [STEP_BITS-1:0] STEP_X1_HI    = 4'd1;
  localparam logic [STEP_BITS-1:0] STEP_X1_LO    = 4'd2;
  localparam logic [STEP_BITS-1:0] STEP_X2_HI    = 4'd3;
  localparam logic [STEP_BITS-1:0] STEP_X2_LO    = 4'd4;
  localparam logic [STEP_BITS-1:0] STEP_RASET    = 4'd5;
  localparam logic [STEP_BITS-1:0] STEP_Y1_HI    = 4'd6;
  localparam logic [STEP_BITS-1:0] STEP_Y1_LO    = 4'd7;
  localparam logic [STEP_BITS-1:0] STEP_Y2_HI    = 4'd8;
  localparam logic [STEP_BITS-1:0] STEP_Y2_LO    = 4'd9;
  localparam logic [STEP_BITS-1:0] STEP_RAMWR    = 4'd10;
  localparam logic [STEP_BITS-1:0] STEP_COLOR_HI = 4'd11;
  localparam logic [STEP_BITS-1:0] STEP_COLOR_LO = 4'd12;
  localparam logic [STEP_BITS-1:0] STEP_CMD      = 4'd0;
  localparam logic [STEP_BITS-1:0] STEP_DATA     = 4'd1;

  job_t                 job_r, job_nxt;
  logic                 busy_r, busy_nxt;
  logic [STEP_BITS-1:0] step_r, step_nxt, last_r, last_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_r, out_nxt;
  out_item_t            cur;
  logic                 adv, done, load;

  assign empty    = !out_valid_r;
  assign out_data = out_r;
  assign adv      = !out_valid_r || pop;
  assign done     = busy_r && adv && (step_r == last_r);
  assign load     = q_valid && (!busy_r || done);
  assign q_pop    = load;

  // byte for the current step
  always_comb begin
    cur           = '0;
    cur.is_data   = 1'b1;
    cur.last_byte = (step_r == last_r);
    if (job_r.kind == JOB_CMD) begin
      case (step_r)
        STEP_CMD: begin
          cur.out_byte = job_r.cmd;
          cur.is_data  = 1'b0;
        end
        default: cur.out_byte = job_r.data;
      endcase
    end else begin
      case (step_r)
        STEP_CASET: begin
          cur.out_byte = CMD_CASET;
          cur.is_data  = 1'b0;
        end
        STEP_X1_HI: cur.out_byte = job_r.x1[15:8];
        STEP_X1_LO: cur.out_byte = job_r.x1[7:0] & BYTE_MASK;
        STEP_X2_HI: cur.out_byte = job_r.x2[15:8];
        STEP_X2_LO: cur.out_byte = job_r.x2[7:0];
        STEP_RASET: begin
          cur.out_byte = CMD_RASET;
          cur.is_data  = 1'b0;
        end
        STEP_Y1_HI: cur.out_byte = job_r.y1[15:8];
        STEP_Y1_LO: cur.out_byte = job_r.y1[7:0];
        STEP_Y2_HI: cur.out_byte = job_r.y2[15:8];
        STEP_Y2_LO: cur.out_byte = job_r.y2[7:0];
        STEP_RAMWR: begin
          cur.out_byte = CMD_RAMWR;
          cur.is_data  = 1'b0;
        end
        STEP_COLOR_HI: cur.out_byte = job_r.color[15:8];
        default: cur.out_byte = job_r.color[7:0];
      endcase
    end
  end

  always_comb begin
    job_nxt       = job_r;
    busy_nxt      = busy_r;
    step_nxt      = step_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (adv) begin
      out_valid_nxt = busy_r;
      out_nxt       = cur;
      if (busy_r) begin
        step_nxt = step_r + STEP_BITS'(1);
      end
      if (done) begin
        busy_nxt = 1'b0;
      end
    end
    if (load) begin
      job_nxt  = q_job;
      busy_nxt = 1'b1;
      case (q_job.kind)
        JOB_COLOR: begin
          step_nxt = STEP_COLOR_HI;
          last_nxt = STEP_COLOR_LO;
        end
        JOB_CMD: begin
          step_nxt = STEP_CMD;
          last_nxt = q_job.has_data ? STEP_DATA : STEP_CMD;
        end
        default: begin
          step_nxt = STEP_CASET;
          last_nxt = q_job.with_color ? STEP_COLOR_LO : STEP_RAMWR;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    job_r  <= job_nxt;
    step_r <= step_nxt;
    last_r <= last_nxt;
    out_r  <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: rtl/lcd_window_write_sequencer_core.sv
// top level of the lcd window write sequencer
// depends on lwws_pkg, lwws_front, lwws_queue and lwws_back
//
// usage:
// - requests go in through a queue-style port: an item transfers on a clock edge
//   with push high and full low; in_data carries the request fields
// - panel bytes come out the same way: while empty is low, out_data holds the
//   oldest byte, with its data/command level and a flag on the last byte of a
//   request; it transfers on an edge with pop high
// - configuration writes go through cfg_valid/cfg_ready (ready always high),
//   cfg_index selects width, height, column offset or row offset
// - the first byte of a request passes through the job queue, the job register and
//   the output register before it shows on out_data; the byte sequencer sends one byte
//   per cycle while pop is not held low: a colour item gives 2 bytes, a pixel 13, a run
//   or window 11, a rotation 2 and other commands 1; requests that give no bytes queue nothing
// - a two-entry job queue and the output register sit between input and output,
//   so requests keep transferring while the receiver holds pop low until the
//   queue fills; a stalled byte stays on out_data unchanged
// - synchronous reset empties the queue and output, closes any open window and
//   restores 240x320 with zero offsets
module lcd_window_write_sequencer_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lwws_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [lwws_pkg::COORD_BITS-1:0]   cfg_data,
  input  logic                              push,
  output logic                              full,
  input  lwws_pkg::in_item_t                in_data,
  output logic                              empty,
  input  logic                              pop,
  output lwws_pkg::out_item_t               out_data
);
  import lwws_pkg::*;

  logic q_push, q_full, q_pop, q_valid;
  job_t q_in_job, q_out_job;

  assign full = q_full;

  lwws_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .in_data   (in_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (q_in_job)
  );

  lwws_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (q_push),
    .job_i   (q_in_job),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .job_o   (q_out_job)
  );

  lwws_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_job    (q_out_job),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

`ifndef NO_ASSERTIONS
  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("job written into a full queue");

  a_pop_has_job: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("job taken from an empty queue");

  a_madctl_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_data.is_data && out_data.out_byte == CMD_MADCTL) |->
      !out_data.last_byte)
    else $error("rotation command sent without its data byte");
`endif

endmodule

FILE: verif/lcd_window_write_sequencer_core_test.sv
// self-checking testbench for lcd_window_write_sequencer_core: directed and random display requests
// against a byte-level predictor of the panel stream, checked in order through a scoreboard class
// depends on lwws_pkg and the rtl of the sequencer
module lcd_window_write_sequencer_core_test;
  import lwws_pkg::*;

  localparam int LIMIT_CYCLES = 500000;
  localparam int DRAIN_CYCLES = 24;
  localparam int HOLD_CYCLES  = 300;
  localparam int COORD_MAX    = (1 << COORD_BITS) - 1;
  localparam int PRINT_CAP    = 100;
  localparam logic [OP_BITS-1:0] OP_UNUSED_FIRST = 4'd9;
  localparam logic [OP_BITS-1:0] OP_UNUSED_LAST  = 4'd15;

  class panel_byte_scoreboard;
    logic [COORD_BITS-1:0] width;
    logic [COORD_BITS-1:0] height;
    logic [COORD_BITS-1:0] col_off;
    logic [COORD_BITS-1:0] row_off;
    logic [LEFT_BITS-1:0]  pixels_owed;
    out_item_t             pending_bytes[$];
    out_item_t             burst[$];
    int                    errors;
    int                    busy_requests;

    function new();
      width = RST_PANEL_WIDTH;
      height = RST_PANEL_HEIGHT;
      col_off = '0;
      row_off = '0;
      pixels_owed = '0;
      errors = 0;
      busy_requests = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [COORD_BITS-1:0] value);
      case (idx)
        CFG_PANEL_WIDTH: width = value;
        CFG_PANEL_HEIGHT: height = value;
        CFG_COL_OFFSET: col_off = value;
        CFG_ROW_OFFSET: row_off = value;
        default: ;
      endcase
    endfunction

    function void add_byte(logic [BYTE_BITS-1:0] b, logic data);
      out_item_t r;
      r.out_byte = b;
      r.is_data = data;
      r.last_byte = 1'b0;
      burst.push_back(r);
    endfunction

    function void add_span(logic [BYTE_BITS-1:0] cmd, logic [ADDR_BITS-1:0] a,
                           logic [ADDR_BITS-1:0] b);
      add_byte(cmd, 1'b0);
      add_byte(a[15:8], 1'b1);
      add_byte(a[7:0], 1'b1);
      add_byte(b[15:8], 1'b1);
      add_byte(b[7:0], 1'b1);
    endfunction

    function void add_window(logic [ADDR_BITS-1:0] x1, logic [ADDR_BITS-1:0] x2,
                             logic [ADDR_BITS-1:0] y1, logic [ADDR_BITS-1:0] y2);
      add_span(CMD_CASET, x1, x2);
      add_span(CMD_RASET, y1, y2);
      add_byte(CMD_RAMWR, 1'b0);
    endfunction

    function void add_color(logic [COLOR_BITS-1:0] c);
      add_byte(c[15:8], 1'b1);
      add_byte(c[7:0], 1'b1);
    endfunction

    function void note_request(in_item_t r);
      logic [ADDR_BITS-1:0]  xa;
      logic [ADDR_BITS-1:0]  ya;
      logic [COORD_BITS:0]   run_end;
      logic [BYTE_BITS-1:0]  rot;
      burst.delete();
      xa = ADDR_BITS'(r.x_start) + ADDR_BITS'(col_off);
      ya = ADDR_BITS'(r.y_start) + ADDR_BITS'(row_off);
      run_end = (COORD_BITS + 1)'(r.x_start) + (COORD_BITS + 1)'(r.run_length);
      case (r.opcode)
        OP_PIXEL: begin
          if (r.x_start < width && r.y_start < height) begin
            pixels_owed = '0;
            add_window(xa, xa, ya, ya);
            add_color(r.color);
          end
        end
        OP_RUN: begin
          pixels_owed = '0;
          if (r.run_length != 0 && run_end <= width && r.y_start < height) begin
            add_window(xa, xa + ADDR_BITS'(r.run_length) - 1'b1, ya, ya);
            pixels_owed = LEFT_BITS'(r.run_length);
          end
        end
        OP_WINDOW: begin
          pixels_owed = '0;
          if (r.x_end >= r.x_start && r.y_end >= r.y_start) begin
            add_window(ADDR_BITS'(r.x_start), ADDR_BITS'(r.x_end),
                       ADDR_BITS'(r.y_start), ADDR_BITS'(r.y_end));
            pixels_owed = (LEFT_BITS'(r.x_end) - LEFT_BITS'(r.x_start) + 1'b1) *
                          (LEFT_BITS'(r.y_end) - LEFT_BITS'(r.y_start) + 1'b1);
          end
        end
        OP_COLOR: begin
          if (pixels_owed != 0) begin
            add_color(r.color);
            pixels_owed = pixels_owed - 1'b1;
          end
        end
        OP_ROTATE: begin
          pixels_owed = '0;
          case (r.direction)
            2'd0: rot = '0;
            2'd1: rot = MAD_MX | MAD_MV;
            2'd2: rot = MAD_MX | MAD_MY;
            default: rot = MAD_MY | MAD_MV;
          endcase
          add_byte(CMD_MADCTL, 1'b0);
          add_byte(rot, 1'b1);
        end
        OP_DISP_OFF: begin
          pixels_owed = '0;
          add_byte(CMD_DISP_OFF, 1'b0);
        end
        OP_DISP_ON: begin
          pixels_owed = '0;
          add_byte(CMD_DISP_ON, 1'b0);
        end
        OP_INV_OFF: begin
          pixels_owed = '0;
          add_byte(CMD_INV_OFF, 1'b0);
        end
        OP_INV_ON: begin
          pixels_owed = '0;
          add_byte(CMD_INV_ON, 1'b0);
        end
        default: ;
      endcase
      if (burst.size() > 0) begin
        burst[burst.size() - 1].last_byte = 1'b1;
        busy_requests++;
        foreach (burst[i]) pending_bytes.push_back(burst[i]);
      end
    endfunction

    task report(string msg);
      errors++;
      if (errors <= PRINT_CAP) $display("mismatch: %s", msg);
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (pending_bytes.size() == 0) begin
        report($sformatf("byte %02h with nothing expected", got.out_byte));
        return;
      end
      want = pending_bytes.pop_front();
      if (got.out_byte !== want.out_byte)
        report($sformatf("out_byte %02h, expected %02h", got.out_byte, want.out_byte));
      if (got.is_data !== want.is_data)
        report($sformatf("is_data %b on byte %02h, expected %b", got.is_data,
                         want.out_byte, want.is_data));
      if (got.last_byte !== want.last_byte)
        report($sformatf("last_byte %b on byte %02h, expected %b", got.last_byte,
                         want.out_byte, want.last_byte));
    endtask
  endclass

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [COORD_BITS-1:0]   cfg_data;
  logic                    push;
  logic                    full;
  in_item_t                in_data;
  logic                    empty;
  logic                    pop;
  out_item_t               out_data;

  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int hold_left = 0;
  int cycle_count = 0;
  panel_byte_scoreboard board = new();

  lcd_window_write_sequencer_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .push(push),
    .full(full),
    .in_data(in_data),
    .empty(empty),
    .pop(pop),
    .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // transfer monitors
  always @(posedge clk) begin
    if (rst_n && push && !full) board.note_request(in_data);
    if (rst_n && pop && !empty) board.check_result(out_data);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver with random stalls and a long hold-off on request
  always @(negedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      pop <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      pop <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  function automatic in_item_t req(logic [OP_BITS-1:0] op, int xs, int ys, int xe, int ye,
                                   int len, int color, int dir);
    in_item_t r;
    r.opcode = op;
    r.x_start = COORD_BITS'(xs);
    r.y_start = COORD_BITS'(ys);
    r.x_end = COORD_BITS'(xe);
    r.y_end = COORD_BITS'(ye);
    r.run_length = COORD_BITS'(len);
    r.color = COLOR_BITS'(color);
    r.direction = DIR_BITS'(dir);
    return r;
  endfunction

  function automatic in_item_t any_request();
    in_item_t r;
    r = in_item_t'({$urandom, $urandom, $urandom});
    return r;
  endfunction

  task send_request(in_item_t r);
    bit done;
    done = 1'b0;
    while (!done) begin
      @(negedge clk);
      if ($urandom_range(99) < sender_idle_pct) begin
        push <= 1'b0;
      end else begin
        push <= 1'b1;
        in_data <= r;
      end
      @(posedge clk);
      done = push && !full;
    end
  endtask

  task wait_drained();
    @(negedge clk);
    push <= 1'b0;
    while (board.pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task write_reg(logic [CFG_IDX_BITS-1:0] idx, int value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= COORD_BITS'(value);
    do @(posedge clk); while (!cfg_ready);
    board.set_reg(idx, COORD_BITS'(value));
  endtask

  task write_config(int w, int h, int co, int ro);
    write_reg(CFG_PANEL_WIDTH, w);
    write_reg(CFG_PANEL_HEIGHT, h);
    write_reg(CFG_COL_OFFSET, co);
    write_reg(CFG_ROW_OFFSET, ro);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // run or window openings followed by colour transfers, pixels, panel commands or random noise
  task run_sequence();
    in_item_t r;
    int pick;
    int w;
    int len;
    int owed;
    int xs;
    int ys;
    int xe;
    int ye;
    r = any_request();
    pick = $urandom_range(99);
    w = board.width;
    if (pick < 20) begin
      send_request(r);
    end else if (pick < 40) begin
      r.opcode = OP_PIXEL;
      r.x_start = COORD_BITS'($urandom_range(w - 1));
      r.y_start = COORD_BITS'($urandom_range(int'(board.height) - 1));
      send_request(r);
    end else if (pick < 52) begin
      case ($urandom_range(4))
        0: r.opcode = OP_ROTATE;
        1: r.opcode = OP_DISP_OFF;
        2: r.opcode = OP_DISP_ON;
        3: r.opcode = OP_INV_OFF;
        default: r.opcode = OP_INV_ON;
      endcase
      send_request(r);
    end else begin
      if ($urandom_range(1)) begin
        if ($urandom_range(9) == 0) len = $urandom_range(1, w);
        else len = $urandom_range(1, (w < 8) ? w : 8);
        r.opcode = OP_RUN;
        r.run_length = COORD_BITS'(len);
        r.x_start = COORD_BITS'($urandom_range(w - len));
        r.y_start = COORD_BITS'($urandom_range(int'(board.height) - 1));
        owed = len;
      end else begin
        xs = $urandom_range(COORD_MAX);
        ys = $urandom_range(COORD_MAX);
        if ($urandom_range(9) == 0) begin
          xe = $urandom_range(xs, COORD_MAX);
          ye = $urandom_range(ys, COORD_MAX);
        end else begin
          xe = xs + $urandom_range(3);
          ye = ys + $urandom_range(3);
          if (xe > COORD_MAX) xe = COORD_MAX;
          if (ye > COORD_MAX) ye = COORD_MAX;
        end
        r.opcode = OP_WINDOW;
        r.x_start = COORD_BITS'(xs);
        r.y_start = COORD_BITS'(ys);
        r.x_end = COORD_BITS'(xe);
        r.y_end = COORD_BITS'(ye);
        owed = (xe - xs + 1) * (ye - ys + 1);
      end
      send_request(r);
      repeat ($urandom_range(0, ((owed < 6) ? owed : 6) + 1)) begin
        r = any_request();
        r.opcode = OP_COLOR;
        send_request(r);
      end
    end
  endtask

  task random_phase(int count);
    int target;
    target = board.busy_requests + count;
    while (board.busy_requests < target) run_sequence();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    push = 1'b0;
    in_data = '0;
    pop = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed requests at the reset panel size, no idling
    send_request(req(OP_PIXEL, 0, 0, 0, 0, 0, 16'h0000, 0));
    send_request(req(OP_PIXEL, 239, 319, COORD_MAX, COORD_MAX, COORD_MAX, 16'hFFFF, 3));
    send_request(req(OP_PIXEL, 240, 0, 0, 0, 0, 16'h1111, 0));
    send_request(req(OP_PIXEL, 0, 320, 0, 0, 0, 16'h2222, 0));
    send_request(req(OP_RUN, 0, 0, 0, 0, 2, 16'h0000, 0));
    send_request(req(OP_COLOR, 0, 0, 0, 0, 0, 16'hA5A5, 0));
    send_request(req(OP_COLOR, 0, 0, 0, 0, 0, 16'h5A5A, 0));
    send_request(req(OP_COLOR, 0, 0, 0, 0, 0, 16'hFFFF, 0));
    send_request(req(OP_RUN, 0, 0, 0, 0, 0, 16'h0000, 0));
    send_request(req(OP_RUN, 200, 0, 0, 0, 41, 16'h0000, 0));
    send_request(req(OP_RUN, 200, 319, 0, 0, 40, 16'h0000, 0));
    send_request(req(OP_COLOR, 0, 0, 0, 0, 0, 16'h8001, 0));
    send_request(req(OP_WINDOW, 5, 0, 4, 9, 0, 16'h0000, 0));
    send_request(req(OP_COLOR, 0, 0, 0, 0, 0, 16'h3C3C, 0));
    send_request(req(OP_WINDOW, 0, 9, 3, 8, 0, 16'h0000, 0));
    send_request(req(OP_WINDOW, 0, 0, COORD_MAX, COORD_MAX, 0, 16'h0000, 0));
    send_request(req(OP_COLOR, 0, 0, 0, 0, 0, 16'h1234, 0));
    send_request(req(OP_ROTATE, 0, 0, 0, 0, 0, 16'h0000, 0));
    send_request(req(OP_ROTATE, 0, 0, 0, 0, 0, 16'h0000, 1));
    send_request(req(OP_ROTATE, 0, 0, 0, 0, 0, 16'h0000, 2));
    send_request(req(OP_ROTATE, 0, 0, 0, 0, 0, 16'h0000, 3));
    send_request(req(OP_DISP_OFF, 0, 0, 0, 0, 0, 16'h0000, 0));
    send_request(req(OP_DISP_ON, 0, 0, 0, 0, 0, 16'h0000, 0));
    send_request(req(OP_INV_OFF, 0, 0, 0, 0, 0, 16'h0000, 0));
    send_request(req(OP_INV_ON, 0, 0, 0, 0, 0, 16'h0000, 0));
    send_request(req(OP_UNUSED_FIRST, 0, 0, 0, 0, 0, 16'h0000, 0));
    send_request(req(OP_UNUSED_LAST, 0, 0, 0, 0, 0, 16'h0000, 0));
    wait_drained();

    // largest panel and offsets, idle sender
    write_config(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
    sender_idle_pct = 52;
    receiver_stall_pct = 0;
    random_phase(20);
    wait_drained();

    // one-pixel panel, stalling receiver
    write_config(1, 1, 0, 0);
    sender_idle_pct = 0;
    receiver_stall_pct = 52;
    random_phase(15);
    wait_drained();

    // random panel, both sides idle, long receiver hold-off while requests keep coming
    write_config($urandom_range(1, COORD_MAX), $urandom_range(1, COORD_MAX),
                 $urandom_range(COORD_MAX), $urandom_range(COORD_MAX));
    sender_idle_pct = 29;
    receiver_stall_pct = 29;
    @(posedge clk);
    hold_left = HOLD_CYCLES;
    random_phase(30);
    wait_drained();

    // another random panel, no idling
    write_config($urandom_range(1, COORD_MAX), $urandom_range(1, COORD_MAX),
                 $urandom_range(COORD_MAX), $urandom_range(COORD_MAX));
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    random_phase(25);
    wait_drained();

    if (board.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
